// File: rtl/core/uct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uct_pkg: shared types and case tables for the Unicode case toggle
// Holds the pair table, the range table, the circled-letter bounds and the
// operation codes that travel down the pipeline.
// ----------------------------------------------------------------------------
package uct_pkg;

    localparam int CP_W      = 21;
    localparam int TDATA_W   = 24;
    localparam int KEY_W     = 16;
    localparam int MSK_W     = 10;
    localparam int PAIR_CNT  = 86;
    localparam int RANGE_CNT = 41;

    localparam logic [KEY_W-1:0] CIRC_UP_LO = 16'h24b6;
    localparam logic [KEY_W-1:0] CIRC_UP_HI = 16'h24cf;
    localparam logic [KEY_W-1:0] CIRC_LO_LO = 16'h24d0;
    localparam logic [KEY_W-1:0] CIRC_LO_HI = 16'h24e9;
    localparam logic [CP_W-1:0]  CIRC_DIST  = 21'd26;

    // Operation applied in the last stage
    typedef enum logic [1:0] {
        OP_PASS,
        OP_XOR,
        OP_ADD,
        OP_SUB
    } op_t;

    typedef struct packed {
        logic [KEY_W-1:0] first;
        logic [KEY_W-1:0] second;
        logic [MSK_W-1:0] msk;
    } pair_t;

    typedef struct packed {
        logic [KEY_W-1:0] lo;
        logic [KEY_W-1:0] hi;
        logic [MSK_W-1:0] msk;
    } range_t;

    // Exact pairs: either member matches, first hit in table order wins
    localparam pair_t PAIR_TAB [PAIR_CNT] = '{
        '{16'h0139, 16'h013a, 10'h003}, '{16'h013b, 16'h013c, 10'h007},
        '{16'h013d, 16'h013e, 10'h003}, '{16'h013f, 16'h0140, 10'h07f},
        '{16'h0141, 16'h0142, 10'h003}, '{16'h0143, 16'h0144, 10'h007},
        '{16'h0145, 16'h0146, 10'h003}, '{16'h0147, 16'h0148, 10'h00f},
        '{16'h0178, 16'h00ff, 10'h187}, '{16'h0179, 16'h017a, 10'h003},
        '{16'h017b, 16'h017c, 10'h007}, '{16'h017d, 16'h017e, 10'h003},
        '{16'h0181, 16'h0253, 10'h3d2}, '{16'h0186, 16'h0254, 10'h3d2},
        '{16'h0187, 16'h0188, 10'h00f}, '{16'h018a, 16'h0257, 10'h3dd},
        '{16'h018b, 16'h018c, 10'h007}, '{16'h018e, 16'h0258, 10'h3d6},
        '{16'h018f, 16'h0259, 10'h3d6}, '{16'h0190, 16'h025b, 10'h3cb},
        '{16'h0191, 16'h0192, 10'h003}, '{16'h0193, 16'h0260, 10'h3f3},
        '{16'h0194, 16'h0263, 10'h3f7}, '{16'h0196, 16'h0269, 10'h3ff},
        '{16'h0197, 16'h0268, 10'h3ff}, '{16'h0198, 16'h0199, 10'h001},
        '{16'h019c, 16'h026f, 10'h3f3}, '{16'h019d, 16'h0272, 10'h3ef},
        '{16'h01a7, 16'h01a8, 10'h00f}, '{16'h01a9, 16'h0283, 10'h32a},
        '{16'h01ac, 16'h01ad, 10'h001}, '{16'h01ae, 16'h0288, 10'h326},
        '{16'h01af, 16'h01b0, 10'h01f}, '{16'h01b1, 16'h028a, 10'h33b},
        '{16'h01b2, 16'h028b, 10'h339}, '{16'h01b3, 16'h01b4, 10'h007},
        '{16'h01b5, 16'h01b6, 10'h003}, '{16'h01b7, 16'h0292, 10'h325},
        '{16'h01b8, 16'h01b9, 10'h001}, '{16'h01bc, 16'h01bd, 10'h001},
        '{16'h01c4, 16'h01c6, 10'h002}, '{16'h01c7, 16'h01c9, 10'h00e},
        '{16'h01ca, 16'h01cc, 10'h006}, '{16'h01cd, 16'h01ce, 10'h003},
        '{16'h01cf, 16'h01d0, 10'h01f}, '{16'h01d1, 16'h01d2, 10'h003},
        '{16'h01d3, 16'h01d4, 10'h007}, '{16'h01d5, 16'h01d6, 10'h003},
        '{16'h01d7, 16'h01d8, 10'h00f}, '{16'h01d9, 16'h01da, 10'h003},
        '{16'h01db, 16'h01dc, 10'h007}, '{16'h01de, 16'h01df, 10'h001},
        '{16'h01f1, 16'h01f3, 10'h002}, '{16'h01f4, 16'h01f5, 10'h001},
        '{16'h0386, 16'h03ac, 10'h02a}, '{16'h0388, 16'h03ad, 10'h025},
        '{16'h0389, 16'h03ae, 10'h027}, '{16'h038a, 16'h03af, 10'h025},
        '{16'h038c, 16'h03cc, 10'h040}, '{16'h038e, 16'h03cd, 10'h043},
        '{16'h038f, 16'h03ce, 10'h041}, '{16'h04c1, 16'h04c2, 10'h003},
        '{16'h04c3, 16'h04c4, 10'h007}, '{16'h04c7, 16'h04c8, 10'h00f},
        '{16'h04cb, 16'h04cc, 10'h007}, '{16'h1f59, 16'h1f51, 10'h008},
        '{16'h1f5b, 16'h1f53, 10'h008}, '{16'h1f5d, 16'h1f55, 10'h008},
        '{16'h1f5f, 16'h1f57, 10'h008}, '{16'h1fba, 16'h1f70, 10'h0ca},
        '{16'h1fbb, 16'h1f71, 10'h0ca}, '{16'h1fc8, 16'h1f72, 10'h0ba},
        '{16'h1fc9, 16'h1f73, 10'h0ba}, '{16'h1fca, 16'h1f74, 10'h0be},
        '{16'h1fcb, 16'h1f75, 10'h0be}, '{16'h1fda, 16'h1f76, 10'h0ac},
        '{16'h1fdb, 16'h1f77, 10'h0ac}, '{16'h1fea, 16'h1f7a, 10'h090},
        '{16'h1feb, 16'h1f7b, 10'h090}, '{16'h1fec, 16'h1fe5, 10'h009},
        '{16'h1ff8, 16'h1f78, 10'h080}, '{16'h1ff9, 16'h1f79, 10'h080},
        '{16'h1ffa, 16'h1f7c, 10'h086}, '{16'h1ffb, 16'h1f7d, 10'h086},
        '{16'h2112, 16'h2113, 10'h001}, '{16'h2130, 16'h212f, 10'h01f}
    };

    // Inclusive ranges, tried only when no pair matches
    localparam range_t RANGE_TAB [RANGE_CNT] = '{
        '{16'h0041, 16'h005a, 10'h020}, '{16'h0061, 16'h007a, 10'h020},
        '{16'h00c0, 16'h00de, 10'h020}, '{16'h00e0, 16'h00fe, 10'h020},
        '{16'h0100, 16'h012f, 10'h001}, '{16'h0132, 16'h0137, 10'h001},
        '{16'h014a, 16'h0177, 10'h001}, '{16'h0182, 16'h0185, 10'h001},
        '{16'h01a0, 16'h01a5, 10'h001}, '{16'h01e0, 16'h01ef, 10'h001},
        '{16'h01fa, 16'h01ff, 10'h001}, '{16'h0200, 16'h0217, 10'h001},
        '{16'h0391, 16'h039f, 10'h020}, '{16'h03a0, 16'h03ab, 10'h060},
        '{16'h03b1, 16'h03bf, 10'h020}, '{16'h03c0, 16'h03cb, 10'h060},
        '{16'h03e2, 16'h03ef, 10'h001}, '{16'h0401, 16'h040f, 10'h050},
        '{16'h0410, 16'h041f, 10'h020}, '{16'h0420, 16'h042f, 10'h060},
        '{16'h0430, 16'h043f, 10'h020}, '{16'h0440, 16'h044f, 10'h060},
        '{16'h0451, 16'h045f, 10'h050}, '{16'h0460, 16'h0481, 10'h001},
        '{16'h0490, 16'h04bf, 10'h001}, '{16'h04d0, 16'h04f9, 10'h001},
        '{16'h0531, 16'h053f, 10'h050}, '{16'h0540, 16'h054f, 10'h030},
        '{16'h0550, 16'h0556, 10'h0d0}, '{16'h0561, 16'h056f, 10'h050},
        '{16'h0570, 16'h057f, 10'h030}, '{16'h0580, 16'h0586, 10'h0d0},
        '{16'h1e00, 16'h1e59, 10'h001}, '{16'h1ea0, 16'h1ef9, 10'h001},
        '{16'h1f00, 16'h1f15, 10'h008}, '{16'h1f18, 16'h1f1d, 10'h008},
        '{16'h1f20, 16'h1f45, 10'h008}, '{16'h1f48, 16'h1f4d, 10'h008},
        '{16'h1f60, 16'h1f6f, 10'h008}, '{16'hff21, 16'hff3a, 10'h060},
        '{16'hff41, 16'hff5a, 10'h060}
    };

endpackage
`default_nettype wire

// File: rtl/core/unicode_case_toggle_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// unicode_case_toggle_top: four-stage Unicode simple case toggle
// Matches a code point against fixed pairs, fixed ranges and the circled
// letters, then XORs in the chosen mask or shifts by 26.
// ----------------------------------------------------------------------------
//  channel  | direction | payload (tdata, low bit first)
//  s_axis   | in        | [20:0] code_point, [23:21] zero pad
//  m_axis   | out       | [20:0] toggled_point, [23:21] zero
//
//  One transaction enters per cycle when the output side keeps tready high;
//  each result passes through every stage register before it reaches m_axis.
//  Stages: input register, table compare, first-hit select, apply/output.
//  Each stage advances when the stage after it is empty or moving, so a
//  stall on m_axis backs up stage by stage without loss or repeats.
//  aresetn (synchronous, active low) clears all valid bits.
// ----------------------------------------------------------------------------
module unicode_case_toggle_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [uct_pkg::TDATA_W-1:0]   s_axis_tdata,   // [20:0] code_point
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [uct_pkg::TDATA_W-1:0]        m_axis_tdata    // [20:0] toggled_point
);

    localparam int CW = uct_pkg::CP_W;
    localparam int PN = uct_pkg::PAIR_CNT;
    localparam int RN = uct_pkg::RANGE_CNT;
    localparam int MW = uct_pkg::MSK_W;

    // Stage valid bits
    logic va_reg, vb_reg, vc_reg, vd_reg;
    logic rdy_a, rdy_b, rdy_c, rdy_d;

    // Stage payloads
    logic [CW-1:0] cp_a_reg, cp_a_next;
    logic [CW-1:0] cp_b_reg;
    logic [PN-1:0] pair_hit_reg, pair_hit_next;
    logic [RN-1:0] rng_hit_reg, rng_hit_next;
    logic          circ_up_reg, circ_up_next;
    logic          circ_dn_reg, circ_dn_next;
    logic [CW-1:0] cp_c_reg;
    logic [MW-1:0] msk_c_reg, msk_c_next;
    uct_pkg::op_t  op_c_reg, op_c_next;
    logic [CW-1:0] res_d_reg, res_d_next;

    logic [PN-1:0] pair_first;
    logic [RN-1:0] rng_first;
    logic [MW-1:0] pair_msk, rng_msk;

    // Ready chain: a stage takes new data when empty or when it drains
    assign rdy_d = !vd_reg || m_axis_tready;
    assign rdy_c = !vc_reg || rdy_d;
    assign rdy_b = !vb_reg || rdy_c;
    assign rdy_a = !va_reg || rdy_b;

    assign s_axis_tready = rdy_a;
    assign m_axis_tvalid = vd_reg;
    assign m_axis_tdata  = {{(uct_pkg::TDATA_W - CW){1'b0}}, res_d_reg};

    assign cp_a_next = s_axis_tdata[CW-1:0];

    // Compare against every pair member, range and circled block
    always_comb begin
        for (int i = 0; i < PN; i++) begin
            pair_hit_next[i] =
                (cp_a_reg == {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::PAIR_TAB[i].first}) ||
                (cp_a_reg == {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::PAIR_TAB[i].second});
        end
        for (int j = 0; j < RN; j++) begin
            rng_hit_next[j] =
                (cp_a_reg >= {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::RANGE_TAB[j].lo}) &&
                (cp_a_reg <= {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::RANGE_TAB[j].hi});
        end
        circ_up_next =
            (cp_a_reg >= {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::CIRC_UP_LO}) &&
            (cp_a_reg <= {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::CIRC_UP_HI});
        circ_dn_next =
            (cp_a_reg >= {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::CIRC_LO_LO}) &&
            (cp_a_reg <= {{(CW - uct_pkg::KEY_W){1'b0}}, uct_pkg::CIRC_LO_HI});
    end

    // Keep only the lowest-index hit, then gather its mask
    assign pair_first = pair_hit_reg & (~pair_hit_reg + {{(PN - 1){1'b0}}, 1'b1});
    assign rng_first  = rng_hit_reg & (~rng_hit_reg + {{(RN - 1){1'b0}}, 1'b1});

    always_comb begin
        pair_msk = '0;
        rng_msk  = '0;
        for (int i = 0; i < PN; i++) begin
            pair_msk = pair_msk | ({MW{pair_first[i]}} & uct_pkg::PAIR_TAB[i].msk);
        end
        for (int j = 0; j < RN; j++) begin
            rng_msk = rng_msk | ({MW{rng_first[j]}} & uct_pkg::RANGE_TAB[j].msk);
        end
    end

    // Rule priority: pairs, ranges, circled capitals, circled small letters
    always_comb begin
        msk_c_next = '0;
        op_c_next  = uct_pkg::OP_PASS;
        if (|pair_hit_reg) begin
            msk_c_next = pair_msk;
            op_c_next  = uct_pkg::OP_XOR;
        end else if (|rng_hit_reg) begin
            msk_c_next = rng_msk;
            op_c_next  = uct_pkg::OP_XOR;
        end else if (circ_up_reg) begin
            op_c_next  = uct_pkg::OP_ADD;
        end else if (circ_dn_reg) begin
            op_c_next  = uct_pkg::OP_SUB;
        end
    end

    // Apply the chosen operation
    always_comb begin
        unique case (op_c_reg)
            uct_pkg::OP_XOR:  res_d_next = cp_c_reg ^ {{(CW - MW){1'b0}}, msk_c_reg};
            uct_pkg::OP_ADD:  res_d_next = cp_c_reg + uct_pkg::CIRC_DIST;
            uct_pkg::OP_SUB:  res_d_next = cp_c_reg - uct_pkg::CIRC_DIST;
            uct_pkg::OP_PASS: res_d_next = cp_c_reg;
            default:          res_d_next = cp_c_reg;
        endcase
    end

    // Valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end else begin
            if (rdy_a) va_reg <= s_axis_tvalid;
            if (rdy_b) vb_reg <= va_reg;
            if (rdy_c) vc_reg <= vb_reg;
            if (rdy_d) vd_reg <= vc_reg;
        end
    end

    // Payload registers: advance with their stage, hold on stall
    always_ff @(posedge aclk) begin
        if (rdy_a) begin
            cp_a_reg <= cp_a_next;
        end
        if (rdy_b) begin
            cp_b_reg     <= cp_a_reg;
            pair_hit_reg <= pair_hit_next;
            rng_hit_reg  <= rng_hit_next;
            circ_up_reg  <= circ_up_next;
            circ_dn_reg  <= circ_dn_next;
        end
        if (rdy_c) begin
            cp_c_reg  <= cp_b_reg;
            msk_c_reg <= msk_c_next;
            op_c_reg  <= op_c_next;
        end
        if (rdy_d) begin
            res_d_reg <= res_d_next;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/uct_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// uct_checker: port-level checks for the case toggle pipeline
// Watches latency, reset behavior, output padding and output hold.
// ----------------------------------------------------------------------------
module uct_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_axis_tvalid,
    input wire logic                          s_axis_tready,
    input wire logic                          m_axis_tvalid,
    input wire logic                          m_axis_tready,
    input wire logic [uct_pkg::TDATA_W-1:0]   m_axis_tdata
);

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("m_axis_tvalid high after reset");

    // An accepted transaction shows up on m_axis while the output keeps flowing
    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready) ##1 m_axis_tready ##1 m_axis_tready
            ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing after pipeline latency");

    // Padding bits above the code point stay zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |->
            (m_axis_tdata[uct_pkg::TDATA_W-1:uct_pkg::CP_W] == '0))
        else $error("nonzero padding in m_axis_tdata");

    // A stalled result holds its data
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind unicode_case_toggle_top uct_checker u_uct_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
